// File: sv/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
// property checked every clock outside reset
`define CAU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked only while the result register is loaded
`define CAU_CHECK_RES(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) res_valid |-> (prop)) else $error(msg);
`endif

// File: sv/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit
package cau_pkg;
  localparam int DATA_W = 16;
  localparam int FRAC_W = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = PROD_W;
  localparam int QUO_W  = DATA_W + FRAC_W + 1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
    logic signed [DATA_W-1:0] y_re;
    logic signed [DATA_W-1:0] y_im;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     overflow;
    logic                     div_by_zero;
  } out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             re_neg;
    logic             im_neg;
    logic [MAG_W-1:0] re_mag;
    logic [MAG_W-1:0] im_mag;
    logic [MAG_W-1:0] den;
    logic             dz;
  } mid_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             re_neg;
    logic             im_neg;
    logic             re_cap;
    logic             im_cap;
    logic             dz;
    logic [MAG_W-1:0] den;
    logic [MAG_W-1:0] re_rem;
    logic [MAG_W-1:0] im_rem;
    logic [QUO_W-1:0] re_sh;
    logic [QUO_W-1:0] im_sh;
    logic [QUO_W-1:0] re_q;
    logic [QUO_W-1:0] im_q;
  } div_t;
endpackage

// File: sv/cau_front.sv
// Products, sums and sign/magnitude split (three stages)
module cau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  output cau_pkg::mid_t out_data
);
  logic v1, v2;
  logic [1:0] k1, k2;
  logic signed [cau_pkg::PROD_W-1:0] ac, bd, ad, bc, cc, dd;
  logic signed [cau_pkg::DATA_W:0] as_re, as_im;
  logic signed [cau_pkg::SUM_W-1:0] re2, im2, re2_next, im2_next;
  logic [cau_pkg::MAG_W-1:0] den2;
  logic [cau_pkg::SUM_W-1:0] re_abs, im_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= in_data.kind;
      ac <= in_data.x_re * in_data.y_re;
      bd <= in_data.x_im * in_data.y_im;
      ad <= in_data.x_re * in_data.y_im;
      bc <= in_data.x_im * in_data.y_re;
      cc <= in_data.y_re * in_data.y_re;
      dd <= in_data.y_im * in_data.y_im;
      if (in_data.kind == cau_pkg::KIND_SUB) begin
        as_re <= {in_data.x_re[cau_pkg::DATA_W-1], in_data.x_re}
               - {in_data.y_re[cau_pkg::DATA_W-1], in_data.y_re};
        as_im <= {in_data.x_im[cau_pkg::DATA_W-1], in_data.x_im}
               - {in_data.y_im[cau_pkg::DATA_W-1], in_data.y_im};
      end else begin
        as_re <= {in_data.x_re[cau_pkg::DATA_W-1], in_data.x_re}
               + {in_data.y_re[cau_pkg::DATA_W-1], in_data.y_re};
        as_im <= {in_data.x_im[cau_pkg::DATA_W-1], in_data.x_im}
               + {in_data.y_im[cau_pkg::DATA_W-1], in_data.y_im};
      end
    end
  end

  always_comb begin
    case (k1)
      cau_pkg::KIND_MUL: begin
        re2_next = cau_pkg::SUM_W'(ac) - cau_pkg::SUM_W'(bd);
        im2_next = cau_pkg::SUM_W'(ad) + cau_pkg::SUM_W'(bc);
      end
      cau_pkg::KIND_DIV: begin
        re2_next = cau_pkg::SUM_W'(ac) + cau_pkg::SUM_W'(bd);
        im2_next = cau_pkg::SUM_W'(bc) - cau_pkg::SUM_W'(ad);
      end
      default: begin
        re2_next = cau_pkg::SUM_W'(as_re);
        im2_next = cau_pkg::SUM_W'(as_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2 <= k1;
      re2 <= re2_next;
      im2 <= im2_next;
      den2 <= cau_pkg::MAG_W'($unsigned(cc)) + cau_pkg::MAG_W'($unsigned(dd));
    end
  end

  assign re_abs = re2[cau_pkg::SUM_W-1] ? -re2 : re2;
  assign im_abs = im2[cau_pkg::SUM_W-1] ? -im2 : im2;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.kind   <= k2;
      out_data.re_neg <= re2[cau_pkg::SUM_W-1];
      out_data.im_neg <= im2[cau_pkg::SUM_W-1];
      out_data.re_mag <= re_abs[cau_pkg::MAG_W-1:0];
      out_data.im_mag <= im_abs[cau_pkg::MAG_W-1:0];
      out_data.den    <= den2;
      out_data.dz     <= (den2 == '0);
    end
  end
endmodule

// File: sv/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage
module cau_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cau_pkg::mid_t in_data,
  output logic          out_valid,
  output cau_pkg::div_t out_data
);
  localparam int NST = cau_pkg::QUO_W;
  localparam int HI_W = cau_pkg::MAG_W - cau_pkg::DATA_W;

  cau_pkg::div_t st [0:NST];
  logic [NST:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].kind   <= in_data.kind;
      st[0].re_neg <= in_data.re_neg;
      st[0].im_neg <= in_data.im_neg;
      st[0].dz     <= in_data.dz;
      st[0].den    <= in_data.den;
      st[0].re_q   <= '0;
      st[0].im_q   <= '0;
      if (in_data.kind == cau_pkg::KIND_DIV) begin
        st[0].re_cap <= {{cau_pkg::DATA_W{1'b0}}, in_data.re_mag}
                     >= {in_data.den, {cau_pkg::DATA_W{1'b0}}};
        st[0].im_cap <= {{cau_pkg::DATA_W{1'b0}}, in_data.im_mag}
                     >= {in_data.den, {cau_pkg::DATA_W{1'b0}}};
        st[0].re_rem <= {{cau_pkg::DATA_W{1'b0}}, in_data.re_mag[cau_pkg::MAG_W-1 -: HI_W]};
        st[0].im_rem <= {{cau_pkg::DATA_W{1'b0}}, in_data.im_mag[cau_pkg::MAG_W-1 -: HI_W]};
        st[0].re_sh  <= {in_data.re_mag[cau_pkg::DATA_W-1:0], {(NST-cau_pkg::DATA_W){1'b0}}};
        st[0].im_sh  <= {in_data.im_mag[cau_pkg::DATA_W-1:0], {(NST-cau_pkg::DATA_W){1'b0}}};
      end else begin
        st[0].re_cap <= 1'b0;
        st[0].im_cap <= 1'b0;
        st[0].re_rem <= in_data.re_mag;
        st[0].im_rem <= in_data.im_mag;
        st[0].re_sh  <= '0;
        st[0].im_sh  <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_step
    logic [cau_pkg::MAG_W:0] re_t, im_t, dd;
    cau_pkg::div_t nx;
    always_comb begin
      nx = st[i];
      dd = {1'b0, st[i].den};
      re_t = {st[i].re_rem, st[i].re_sh[NST-1]};
      im_t = {st[i].im_rem, st[i].im_sh[NST-1]};
      if (st[i].kind == cau_pkg::KIND_DIV) begin
        nx.re_sh = {st[i].re_sh[NST-2:0], 1'b0};
        nx.im_sh = {st[i].im_sh[NST-2:0], 1'b0};
        if (re_t >= dd) begin
          nx.re_rem = cau_pkg::MAG_W'(re_t - dd);
          nx.re_q = {st[i].re_q[NST-2:0], 1'b1};
        end else begin
          nx.re_rem = re_t[cau_pkg::MAG_W-1:0];
          nx.re_q = {st[i].re_q[NST-2:0], 1'b0};
        end
        if (im_t >= dd) begin
          nx.im_rem = cau_pkg::MAG_W'(im_t - dd);
          nx.im_q = {st[i].im_q[NST-2:0], 1'b1};
        end else begin
          nx.im_rem = im_t[cau_pkg::MAG_W-1:0];
          nx.im_q = {st[i].im_q[NST-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nx;
      end
    end
  end

  assign out_valid = vld[NST];
  assign out_data  = st[NST];
endmodule

// File: sv/cau_round.sv
// Rounding, saturation and result register
module cau_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cau_pkg::div_t in_data,
  output logic          out_valid,
  output cau_pkg::out_t out_data
);
  localparam logic [cau_pkg::MAG_W:0] HALF = (cau_pkg::MAG_W+1)'(1) << (cau_pkg::FRAC_W - 1);
  localparam logic [cau_pkg::MAG_W:0] LIM  = (cau_pkg::MAG_W+1)'(1) << (cau_pkg::DATA_W - 1);

  logic [cau_pkg::MAG_W:0] re_m, im_m, re_s, im_s;
  logic re_ov, im_ov;
  cau_pkg::out_t res_next;

  always_comb begin
    case (in_data.kind)
      cau_pkg::KIND_MUL: begin
        re_m = ({1'b0, in_data.re_rem} + HALF) >> cau_pkg::FRAC_W;
        im_m = ({1'b0, in_data.im_rem} + HALF) >> cau_pkg::FRAC_W;
      end
      cau_pkg::KIND_DIV: begin
        re_m = in_data.re_cap ? LIM << 1
             : (cau_pkg::MAG_W+1)'(({1'b0, in_data.re_q} + 1'b1) >> 1);
        im_m = in_data.im_cap ? LIM << 1
             : (cau_pkg::MAG_W+1)'(({1'b0, in_data.im_q} + 1'b1) >> 1);
      end
      default: begin
        re_m = {1'b0, in_data.re_rem};
        im_m = {1'b0, in_data.im_rem};
      end
    endcase
    if (in_data.re_neg) begin
      re_ov = re_m > LIM;
      re_s  = re_ov ? LIM : re_m;
      re_s  = -re_s;
    end else begin
      re_ov = re_m > LIM - 1'b1;
      re_s  = re_ov ? LIM - 1'b1 : re_m;
    end
    if (in_data.im_neg) begin
      im_ov = im_m > LIM;
      im_s  = im_ov ? LIM : im_m;
      im_s  = -im_s;
    end else begin
      im_ov = im_m > LIM - 1'b1;
      im_s  = im_ov ? LIM - 1'b1 : im_m;
    end
    if (in_data.kind == cau_pkg::KIND_DIV && in_data.dz) begin
      res_next.res_re      = '0;
      res_next.res_im      = '0;
      res_next.overflow    = 1'b0;
      res_next.div_by_zero = 1'b1;
    end else begin
      res_next.res_re      = re_s[cau_pkg::DATA_W-1:0];
      res_next.res_im      = im_s[cau_pkg::DATA_W-1:0];
      res_next.overflow    = re_ov | im_ov;
      res_next.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end
endmodule

// File: sv/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide on signed Q8.8.
// Pipeline from request to result: 3 front stages, 26 divider stages, 1 output stage.
// Throughput: one request per cycle while the result is not stalled; the divider retires one quotient bit per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; data is not cleared.
module complex_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cau_pkg::in_t  req,
  output logic          res_valid,
  input  logic          res_ready,
  output cau_pkg::out_t res
);
  `include "complex_arithmetic_unit_assert.svh"

  logic en;
  logic mid_valid, div_valid;
  cau_pkg::mid_t mid_data;
  cau_pkg::div_t div_data;

  assign en = !res_valid || res_ready;
  assign req_ready = en;

  cau_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(req_valid), .in_data(req),
    .out_valid(mid_valid), .out_data(mid_data)
  );

  cau_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mid_valid), .in_data(mid_data),
    .out_valid(div_valid), .out_data(div_data)
  );

  cau_round u_round (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(div_valid), .in_data(div_data),
    .out_valid(res_valid), .out_data(res)
  );

  `CAU_CHECK(a_stall_freeze, res_valid && !res_ready |=> res_valid && $stable(res), "stall lost result")
  `CAU_CHECK_RES(a_dz_zero, !res.div_by_zero || (res.res_re == '0 && res.res_im == '0), "dz not zero")
  `CAU_CHECK_RES(a_dz_no_ov, !(res.div_by_zero && res.overflow), "dz with overflow")
endmodule
